@@ rtl/per_channel_mean_stddev_macros.svh @@
// Assertion macros for the block's top module.
`ifndef PER_CHANNEL_MEAN_STDDEV_MACROS_SVH
`define PER_CHANNEL_MEAN_STDDEV_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define PCMS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define PCMS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/pcms_pkg.sv @@
package pcms_pkg;

  localparam int CNT_W = 16;
  localparam int SUM_W = 40;
  localparam int SQ_W  = 64;
  localparam int ALU_W = 80;
  localparam int RAD_W = 96;
  localparam int ROOT_W = 48;
  localparam int SREM_W = 52;
  localparam int QUO_W = 48;

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_DATA = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_EMPTY   = 2'd3;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD_A,
    OP_MUL,
    OP_LOAD_B,
    OP_DIFF,
    OP_SQRT,
    OP_LOAD_M,
    OP_DIV,
    OP_SAVE_M,
    OP_SAVE_S
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [CNT_W-1:0]  cnt;
    logic [SUM_W-1:0]  sum;
    logic [SQ_W-1:0]   sq;
  } dp_ctl_t;

endpackage

@@ rtl/pcms_ram.sv @@
module pcms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/pcms_dp.sv @@
module pcms_dp import pcms_pkg::*; (
  input  logic        clk,
  input  dp_ctl_t     ctl,
  output logic [31:0] mean_q8,
  output logic [31:0] stddev_q8
);

  logic [CNT_W-1:0]  cnt_r;
  logic              sum_neg_r;
  logic [SUM_W-1:0]  smag_r;
  logic [ALU_W-1:0]  mcand_r;
  logic [SUM_W-1:0]  mplier_r;
  logic [ALU_W-1:0]  acc_r;
  logic [ALU_W-1:0]  a_r;
  logic [RAD_W-1:0]  rad_r;
  logic [SREM_W-1:0] srem_r;
  logic [ROOT_W-1:0] root_r;
  logic [QUO_W-1:0]  quo_r;
  logic [CNT_W-1:0]  drem_r;
  logic [31:0]       mean_r;
  logic [31:0]       sd_r;

  logic [SREM_W-1:0] srem_sh;
  logic [CNT_W:0]    drem_sh;
  logic [ALU_W-1:0]  alu_x;
  logic [ALU_W-1:0]  alu_y;
  logic              alu_sub;
  logic [ALU_W:0]    alu_full;
  logic [ALU_W-1:0]  alu_res;
  logic              alu_ge;
  logic [31:0]       mean_sat;

  assign srem_sh = {srem_r[SREM_W-3:0], rad_r[RAD_W-1:RAD_W-2]};
  assign drem_sh = {drem_r, quo_r[QUO_W-1]};

  // The single shared adder: every multiply, difference, square-root and division step runs through it.
  always_comb begin
    alu_x   = '0;
    alu_y   = '0;
    alu_sub = 1'b0;
    case (ctl.op)
      OP_MUL: begin
        alu_x = acc_r;
        alu_y = mcand_r;
      end
      OP_DIFF: begin
        alu_x   = a_r;
        alu_y   = acc_r;
        alu_sub = 1'b1;
      end
      OP_SQRT: begin
        alu_x   = ALU_W'(srem_sh);
        alu_y   = ALU_W'({root_r, 2'b01});
        alu_sub = 1'b1;
      end
      OP_DIV: begin
        alu_x   = ALU_W'(drem_sh);
        alu_y   = ALU_W'(cnt_r);
        alu_sub = 1'b1;
      end
      default: begin
        alu_x = '0;
      end
    endcase
  end

  assign alu_full = {1'b0, alu_x} + {1'b0, (alu_sub ? ~alu_y : alu_y)}
                  + (ALU_W + 1)'(alu_sub);
  assign alu_res  = alu_full[ALU_W-1:0];
  assign alu_ge   = alu_full[ALU_W];

  always_comb begin
    if (sum_neg_r) begin
      if (quo_r > QUO_W'(33'h0_8000_0000)) begin
        mean_sat = 32'h8000_0000;
      end else begin
        mean_sat = 32'(~quo_r + QUO_W'(1));
      end
    end else if (|quo_r[QUO_W-1:31]) begin
      mean_sat = 32'h7fff_ffff;
    end else begin
      mean_sat = quo_r[31:0];
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_LOAD_A: begin
        cnt_r     <= ctl.cnt;
        sum_neg_r <= ctl.sum[SUM_W-1];
        smag_r    <= ctl.sum[SUM_W-1] ? (~ctl.sum + SUM_W'(1)) : ctl.sum;
        mcand_r   <= ALU_W'(ctl.sq);
        mplier_r  <= SUM_W'(ctl.cnt);
        acc_r     <= '0;
      end
      OP_MUL: begin
        if (mplier_r[0]) begin
          acc_r <= alu_res;
        end
        mcand_r  <= mcand_r << 1;
        mplier_r <= mplier_r >> 1;
      end
      OP_LOAD_B: begin
        a_r      <= acc_r;
        mcand_r  <= ALU_W'(smag_r);
        mplier_r <= smag_r;
        acc_r    <= '0;
      end
      OP_DIFF: begin
        rad_r  <= {(alu_ge ? alu_res : ALU_W'(0)), 16'h0000};
        srem_r <= '0;
        root_r <= '0;
      end
      OP_SQRT: begin
        rad_r <= rad_r << 2;
        if (alu_ge) begin
          srem_r <= alu_res[SREM_W-1:0];
          root_r <= {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          srem_r <= srem_sh;
          root_r <= {root_r[ROOT_W-2:0], 1'b0};
        end
      end
      OP_LOAD_M: begin
        quo_r  <= {smag_r, 8'h00};
        drem_r <= '0;
      end
      OP_DIV: begin
        quo_r  <= {quo_r[QUO_W-2:0], alu_ge};
        drem_r <= alu_ge ? alu_res[CNT_W-1:0] : drem_sh[CNT_W-1:0];
      end
      OP_SAVE_M: begin
        mean_r <= mean_sat;
        quo_r  <= root_r;
        drem_r <= '0;
      end
      OP_SAVE_S: begin
        sd_r <= (|quo_r[QUO_W-1:32]) ? 32'hffff_ffff : quo_r[31:0];
      end
      default: begin
        acc_r <= acc_r;
      end
    endcase
  end

  assign mean_q8   = mean_r;
  assign stddev_q8 = sd_r;

endmodule

@@ rtl/per_channel_mean_stddev.sv @@
// Per-sensor running mean and population standard deviation, both Q.8. Raise start
// for one cycle while busy is low; the item is taken at that edge and busy stays high
// until the result has been shown. Each item returns exactly one result, on the out_
// ports for the single cycle in which out_valid is high; it cannot be stalled, so it
// must be captured then. When the sensor ends up empty the arithmetic is skipped;
// otherwise one shared adder runs the two shift-and-add multiplies, the bit-pair
// square root and two restoring divisions one bit per cycle. The accumulator table
// sits in a RAM with a valid bit per sensor, so it reads as zero right after reset.
`include "per_channel_mean_stddev_macros.svh"

module per_channel_mean_stddev import pcms_pkg::*; #(
  parameter int NUM_SENSORS = 16,
  parameter int COUNT_BITS  = 16,
  parameter int SAMPLE_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [3:0]  in_sensor_index,
  input  logic [23:0] in_sample,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [15:0] out_sample_count,
  output logic [31:0] out_mean_q8,
  output logic [31:0] out_stddev_q8
);

  localparam int IDX_W = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
  localparam int ENT_W = COUNT_BITS + SUM_W + SQ_W;

  typedef enum logic [12:0] {
    S_IDLE = 13'b0_0000_0000_0001,
    S_UPD  = 13'b0_0000_0000_0010,
    S_MULA = 13'b0_0000_0000_0100,
    S_LDB  = 13'b0_0000_0000_1000,
    S_MULB = 13'b0_0000_0001_0000,
    S_DIFF = 13'b0_0000_0010_0000,
    S_SQRT = 13'b0_0000_0100_0000,
    S_LDM  = 13'b0_0000_1000_0000,
    S_DIVM = 13'b0_0001_0000_0000,
    S_SAVM = 13'b0_0010_0000_0000,
    S_DIVS = 13'b0_0100_0000_0000,
    S_SAVS = 13'b0_1000_0000_0000,
    S_DONE = 13'b1_0000_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic [5:0] step_r, step_nxt;

  logic [NUM_SENSORS-1:0] valid_r;
  logic [IDX_W-1:0]       idx_r;
  logic [1:0]             cmd_r;
  logic [SUM_W-1:0]       smp_r;
  logic [SQ_W-1:0]        sq_r;
  logic [1:0]             status_r;
  logic [COUNT_BITS-1:0]  count_r;
  logic                   zero_r;

  logic [8:0]             idx_mod;
  logic [IDX_W-1:0]       idx_in;
  logic                   accept;
  logic [SUM_W-1:0]       smp_in;
  logic [SUM_W-1:0]       smag_in;

  logic [ENT_W-1:0]       rdata;
  logic [ENT_W-1:0]       ent;
  logic [COUNT_BITS-1:0]  cnt_old;
  logic [SUM_W-1:0]       sum_old;
  logic [SQ_W-1:0]        sq_old;
  logic [COUNT_BITS-1:0]  cnt_new;
  logic [SUM_W-1:0]       sum_new;
  logic [SQ_W-1:0]        sq_new;
  logic [1:0]             status_new;
  logic                   do_write;

  dp_ctl_t                ctl;
  logic [31:0]            dp_mean;
  logic [31:0]            dp_sd;

  assign accept  = start && !busy;

  // The sensor index folds onto the table through a small constant lookup.
  always_comb begin
    idx_mod = '0;
    for (int i = 0; i < 16; i++) begin
      if (in_sensor_index == 4'(i)) begin
        idx_mod = 9'(i % NUM_SENSORS);
      end
    end
  end

  assign idx_in  = idx_mod[IDX_W-1:0];
  assign smp_in  = SUM_W'($signed(in_sample[SAMPLE_BITS-1:0]));
  assign smag_in = smp_in[SUM_W-1] ? (~smp_in + SUM_W'(1)) : smp_in;

  pcms_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NUM_SENSORS),
    .AW    (IDX_W)
  ) u_table (
    .clk   (clk),
    .we    (do_write),
    .waddr (idx_r),
    .wdata ({cnt_new, sum_new, sq_new}),
    .raddr (idx_in),
    .rdata (rdata)
  );

  assign ent     = valid_r[idx_r] ? rdata : '0;
  assign cnt_old = ent[ENT_W-1 -: COUNT_BITS];
  assign sum_old = ent[SQ_W +: SUM_W];
  assign sq_old  = ent[SQ_W-1:0];

  always_comb begin
    cnt_new    = cnt_old;
    sum_new    = sum_old;
    sq_new     = sq_old;
    status_new = ST_OK;
    do_write   = 1'b0;
    case (cmd_r)
      CMD_ADD: begin
        if (&cnt_old) begin
          status_new = ST_FULL;
        end else begin
          cnt_new  = cnt_old + COUNT_BITS'(1);
          sum_new  = sum_old + smp_r;
          sq_new   = sq_old + sq_r;
          do_write = state_r == S_UPD;
        end
      end
      CMD_REMOVE: begin
        if (cnt_old == '0) begin
          status_new = ST_EMPTY;
        end else begin
          cnt_new  = cnt_old - COUNT_BITS'(1);
          sum_new  = sum_old - smp_r;
          sq_new   = sq_old - sq_r;
          do_write = state_r == S_UPD;
        end
      end
      default: begin
        status_new = ST_OK;
      end
    endcase
    if (status_new == ST_OK && cnt_new == '0) begin
      status_new = ST_NO_DATA;
    end
  end

  always_comb begin
    ctl.op  = OP_NONE;
    ctl.cnt = CNT_W'(cnt_new);
    ctl.sum = sum_new;
    ctl.sq  = sq_new;
    case (state_r)
      S_UPD:  ctl.op = OP_LOAD_A;
      S_MULA: ctl.op = OP_MUL;
      S_LDB:  ctl.op = OP_LOAD_B;
      S_MULB: ctl.op = OP_MUL;
      S_DIFF: ctl.op = OP_DIFF;
      S_SQRT: ctl.op = OP_SQRT;
      S_LDM:  ctl.op = OP_LOAD_M;
      S_DIVM: ctl.op = OP_DIV;
      S_SAVM: ctl.op = OP_SAVE_M;
      S_DIVS: ctl.op = OP_DIV;
      S_SAVS: ctl.op = OP_SAVE_S;
      default: ctl.op = OP_NONE;
    endcase
  end

  pcms_dp u_dp (
    .clk       (clk),
    .ctl       (ctl),
    .mean_q8   (dp_mean),
    .stddev_q8 (dp_sd)
  );

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r - 6'd1;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        step_nxt  = 6'(COUNT_BITS - 1);
        state_nxt = (cnt_new == '0) ? S_DONE : S_MULA;
      end
      S_MULA: begin
        if (step_r == '0) begin
          state_nxt = S_LDB;
        end
      end
      S_LDB: begin
        step_nxt  = 6'(SUM_W - 1);
        state_nxt = S_MULB;
      end
      S_MULB: begin
        if (step_r == '0) begin
          state_nxt = S_DIFF;
        end
      end
      S_DIFF: begin
        step_nxt  = 6'(ROOT_W - 1);
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        if (step_r == '0) begin
          state_nxt = S_LDM;
        end
      end
      S_LDM: begin
        step_nxt  = 6'(QUO_W - 1);
        state_nxt = S_DIVM;
      end
      S_DIVM: begin
        if (step_r == '0) begin
          state_nxt = S_SAVM;
        end
      end
      S_SAVM: begin
        step_nxt  = 6'(QUO_W - 1);
        state_nxt = S_DIVS;
      end
      S_DIVS: begin
        if (step_r == '0) begin
          state_nxt = S_SAVS;
        end
      end
      S_SAVS: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      valid_r <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      if (do_write) begin
        valid_r[idx_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      idx_r <= idx_in;
      cmd_r <= in_command;
      smp_r <= smp_in;
      sq_r  <= SQ_W'(smag_in[23:0] * smag_in[23:0]);
    end
    if (state_r == S_UPD) begin
      status_r <= status_new;
      count_r  <= cnt_new;
      zero_r   <= cnt_new == '0;
    end
  end

  assign busy             = state_r != S_IDLE;
  assign out_valid        = state_r == S_DONE;
  assign out_status       = status_r;
  assign out_sample_count = 16'(count_r);
  assign out_mean_q8      = zero_r ? 32'h0 : dp_mean;
  assign out_stddev_q8    = zero_r ? 32'h0 : dp_sd;

  `PCMS_ASSERT_IMP(a_strobe_busy, out_valid, busy, "result strobe while not busy")
  `PCMS_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
  `PCMS_ASSERT_NXT(a_single_strobe, out_valid, !out_valid, "result strobe longer than a cycle")
  `PCMS_ASSERT_IMP(a_no_data_zero, out_valid && out_status == ST_NO_DATA,
                   out_mean_q8 == 32'h0 && out_stddev_q8 == 32'h0, "no-data result not zero")

endmodule
